### src/balanced_quinary_sum_converter_top_assert.svh
// Assertion macros for the balanced quinary sum converter
`ifndef BALANCED_QUINARY_SUM_CONVERTER_TOP_ASSERT_SVH
`define BALANCED_QUINARY_SUM_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define BQSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bqsc assertion failed");

// next-cycle implication
`define BQSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bqsc assertion failed");

`endif

### src/bqsc_pkg.sv
// Package: types and constants of the balanced quinary sum converter
`timescale 1ns / 1ps
package bqsc_pkg;

   localparam int CountWidth = 5;

   typedef logic [1:0] action_type;
   localparam action_type ACT_DIGIT  = 2'd0;
   localparam action_type ACT_END    = 2'd1;
   localparam action_type ACT_FINISH = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_DIGIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic horner;
      logic add_end;
      logic start_conv;
      logic load_empty;
      logic div_step;
      logic store_digit;
      logic start_emit;
      logic emit_digit;
   } cmd_type;

   typedef struct packed {
      logic value_zero_or_neg;
      logic div_done;
      logic conv_done;
      logic emit_last;
      logic slot_free;
   } status_type;

endpackage

### src/bqsc_if.sv
// Channel interfaces: request and response transactions with valid/ready
`timescale 1ns / 1ps
interface bqsc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic signed [2:0] digit_value;

   modport source (output valid, output action, output digit_value, input ready);
   modport sink (input valid, input action, input digit_value, output ready);
endinterface

interface bqsc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [2:0] digit_value_res;
   logic              last;
   logic              empty_res;

   modport source (output valid, output digit_value_res, output last, output empty_res,
                   input ready);
   modport sink (input valid, input digit_value_res, input last, input empty_res,
                 output ready);
endinterface

### src/bqsc_ctrl.sv
// Controller state machine of the balanced quinary sum converter
`timescale 1ns / 1ps
module bqsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  bqsc_pkg::action_type req_action,
   output logic                 req_ready,
   input  bqsc_pkg::status_type status,
   output bqsc_pkg::cmd_type    cmd,
   output bqsc_pkg::state_type  state
);
   import bqsc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_action)
                  ACT_DIGIT:  cmd.horner  = 1'b1;
                  ACT_END:    cmd.add_end = 1'b1;
                  ACT_FINISH: begin
                     cmd.start_conv = 1'b1;
                     state_in       = ST_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_CHECK: begin
            if (status.value_zero_or_neg) begin
               if (status.slot_free) begin
                  cmd.load_empty = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            cmd.store_digit = 1'b1;
            if (status.conv_done) begin
               cmd.start_emit = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_digit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign state = state_ff;

endmodule

### src/bqsc_dp.sv
// Datapath: Horner accumulation, chunked divide by five, digit buffer, output register
`timescale 1ns / 1ps
module bqsc_dp #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bqsc_pkg::cmd_type    cmd,
   output bqsc_pkg::status_type status,
   input  logic signed [2:0]    req_digit_value,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [2:0]    rsp_digit_value_res,
   output logic                 rsp_last,
   output logic                 rsp_empty_res
);
   import bqsc_pkg::*;

   localparam int IdxWidth   = $clog2(MAX_DIGITS);
   localparam int ChunkBits  = 16;
   localparam int ChunkCount = (VALUE_WIDTH + ChunkBits - 1) / ChunkBits;
   localparam int PadWidth   = ChunkCount * ChunkBits;
   // ceil(2^22 / 5): exact quotient for every dividend below 2^22
   localparam logic [19:0] RecipFive = 20'd838861;

   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;
   logic [VALUE_WIDTH-1:0] sum_ff;
   logic [VALUE_WIDTH-1:0] total;
   logic [PadWidth-1:0]    quo_ff, quo_in, quo_adj;
   logic [2:0]             rem_ff, rem_in;
   logic [ChunkBits+2:0]   div_x;
   logic [ChunkBits+22:0]  div_prod;
   logic [ChunkBits-1:0]   div_q;
   logic [ChunkBits+2:0]   div_r;
   logic [1:0]             step_cnt_ff;
   logic [CountWidth-1:0]  count_ff;
   logic [IdxWidth-1:0]    rd_idx_ff;
   logic [2:0]             digit_in;
   logic [2:0]             buf_mem [MAX_DIGITS];
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_digit_ff;
   logic                   rsp_last_ff;
   logic                   rsp_empty_ff;

   always_comb begin
      cur_in   = (cur_ff << 2) + cur_ff
               + {{(VALUE_WIDTH-3){req_digit_value[2]}}, req_digit_value};
      total    = sum_ff + cur_ff;
      // one chunk per step, most significant first, remainder carried in on top
      div_x    = {rem_ff, quo_ff[PadWidth-1 -: ChunkBits]};
      div_prod = {20'd0, div_x} * {{(ChunkBits+3){1'b0}}, RecipFive};
      div_q    = div_prod[ChunkBits+21:22];
      div_r    = div_x - {1'b0, div_q, 2'b00} - {3'b000, div_q};
      rem_in   = div_r[2:0];
      quo_in   = (quo_ff << ChunkBits) | PadWidth'(div_q);
      // remainders 3 and 4 become digits -2 and -1 with a carry into the quotient
      quo_adj  = quo_ff + PadWidth'(rem_ff > 3'd2);
      digit_in = (rem_ff > 3'd2) ? 3'(rem_ff - 3'd5) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         step_cnt_ff <= '0;
      end else begin
         if (cmd.horner) begin
            cur_ff <= cur_in;
         end
         if (cmd.add_end) begin
            sum_ff <= sum_ff + cur_ff;
            cur_ff <= '0;
         end
         if (cmd.start_conv) begin
            cur_ff      <= '0;
            sum_ff      <= '0;
            count_ff    <= '0;
            step_cnt_ff <= '0;
         end
         if (cmd.div_step) begin
            step_cnt_ff <= step_cnt_ff + 1'b1;
         end
         if (cmd.store_digit) begin
            count_ff    <= count_ff + 1'b1;
            step_cnt_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_conv) begin
         quo_ff <= PadWidth'(total);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end else if (cmd.store_digit) begin
         quo_ff <= quo_adj;
         rem_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_digit) begin
         buf_mem[count_ff[IdxWidth-1:0]] <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_emit) begin
         rd_idx_ff <= count_ff[IdxWidth-1:0];
      end else if (cmd.emit_digit) begin
         rd_idx_ff <= rd_idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_empty || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_empty) begin
         rsp_digit_ff <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_empty_ff <= 1'b1;
      end else if (cmd.emit_digit) begin
         rsp_digit_ff <= buf_mem[rd_idx_ff];
         rsp_last_ff  <= (rd_idx_ff == '0);
         rsp_empty_ff <= 1'b0;
      end
   end

   always_comb begin
      status.value_zero_or_neg = (quo_ff == '0) || quo_ff[VALUE_WIDTH-1];
      status.div_done          = (step_cnt_ff == 2'(ChunkCount - 1));
      status.conv_done         = (quo_adj == '0)
                               || (count_ff == CountWidth'(MAX_DIGITS - 1));
      status.emit_last         = (rd_idx_ff == '0);
      status.slot_free         = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_digit_value_res = rsp_digit_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_empty_res       = rsp_empty_ff;

endmodule

### src/balanced_quinary_sum_converter_top.sv
// Top level of the balanced quinary sum converter
//
// Request channel (req_if): one transaction per cycle while ready carries an
// action and a balanced base-5 digit. Digit transactions run Horner steps on the
// number in progress, end-of-number transactions add it to the running sum; both
// leave the block idle and it is ready again at the next edge. Action 3 is dropped.
// A finish transaction adds the pending number and converts the sum to
// balanced base-5 digits, sent on the response channel (rsp_if) most
// significant first with last set on the final one. A zero or negative sum
// gives a single transaction with empty_res and last set. Otherwise a check
// state, then per digit one 16-bit divide-by-five step per cycle over the
// chunks, most significant first, and a store; then the digits are sent, each
// held back while the output register is full. Request ready is low from the
// finish until the last digit or the empty result sits in the output register.
// A registered response stage holds a result while the receiver stalls; the
// block accepts the next request as soon as the last result sits in that
// register. Synchronous reset clears the number, the sum and the output valid.
`timescale 1ns / 1ps
module balanced_quinary_sum_converter_top #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 28
) (
   input logic       clock,
   input logic       reset,
   bqsc_req_if.sink  req_if,
   bqsc_rsp_if.source rsp_if
);
   import bqsc_pkg::*;

   cmd_type    cmd;
   status_type status;
   state_type  state;

   bqsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .status     (status),
      .cmd        (cmd),
      .state      (state)
   );

   bqsc_dp #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_digit_value     (req_if.digit_value),
      .rsp_ready           (rsp_if.ready),
      .rsp_valid           (rsp_if.valid),
      .rsp_digit_value_res (rsp_if.digit_value_res),
      .rsp_last            (rsp_if.last),
      .rsp_empty_res       (rsp_if.empty_res)
   );

`include "balanced_quinary_sum_converter_top_assert.svh"

   `BQSC_ASSERT_NEXT(a_finish_busy, clock, reset,
      req_if.valid && req_if.ready && (req_if.action == ACT_FINISH), !req_if.ready)
   `BQSC_ASSERT_SAME(a_empty_single, clock, reset,
      rsp_if.valid && rsp_if.empty_res,
      rsp_if.last && (rsp_if.digit_value_res == 3'sd0))
   `BQSC_ASSERT_SAME(a_digit_range, clock, reset,
      rsp_if.valid && !rsp_if.empty_res,
      (rsp_if.digit_value_res != 3'sd3) && (rsp_if.digit_value_res != -3'sd4))
   `BQSC_ASSERT_SAME(a_emit_blocks_req, clock, reset,
      (state == ST_DIVIDE) || (state == ST_DIGIT), !rsp_if.valid || !cmd.emit_digit)

endmodule

### test/bqsc_sum_checker.sv
// Checker for the balanced quinary sum converter: predicts each response transaction and compares
`timescale 1ns / 1ps
module bqsc_sum_checker #(
   parameter int VALUE_WIDTH = 64,
   parameter int MAX_DIGITS  = 28
) (
   input logic  clock,
   input logic  reset,
   bqsc_req_if  req_mon,
   bqsc_rsp_if  rsp_mon,
   output int   error_count,
   output int   pending_count
);
   import bqsc_pkg::*;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      logic signed [2:0] digit;
      logic              last;
      logic              empty;
   } sum_digit_type;

   value_type     number_acc;
   value_type     sum_acc;
   sum_digit_type expected_digits[$];
   int            mismatches = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // adds the pending number, converts the sum to balanced base-5, queues the digits
   task automatic convert_sum();
      value_type         total;
      value_type         quot;
      value_type         rem;
      logic signed [2:0] dbuf [MAX_DIGITS];
      int                n;
      int                k;
      sum_digit_type     item;
      total = sum_acc + number_acc;
      n = 0;
      if (total == '0 || total[VALUE_WIDTH-1]) begin
         item.digit = '0;
         item.last  = 1'b1;
         item.empty = 1'b1;
         expected_digits.push_back(item);
      end else begin
         while (total != '0 && n < MAX_DIGITS) begin
            quot = total / 5;
            rem  = total % 5;
            if (rem <= 2) begin
               dbuf[n] = 3'(rem);
            end else begin
               dbuf[n] = 3'(rem) - 3'd5;
               quot = quot + 1;
            end
            n++;
            total = quot;
         end
         for (k = n - 1; k >= 0; k--) begin
            item.digit = dbuf[k];
            item.last  = (k == 0);
            item.empty = 1'b0;
            expected_digits.push_back(item);
         end
      end
      sum_acc    = '0;
      number_acc = '0;
   endtask

   always @(posedge clock) begin
      sum_digit_type want;
      logic [2:0]    raw;
      if (reset) begin
         number_acc = '0;
         sum_acc    = '0;
         expected_digits.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            raw = req_mon.digit_value;
            case (req_mon.action)
               ACT_DIGIT: begin
                  number_acc = number_acc * 5 + {{(VALUE_WIDTH-3){raw[2]}}, raw};
               end
               ACT_END: begin
                  sum_acc    = sum_acc + number_acc;
                  number_acc = '0;
               end
               ACT_FINISH: begin
                  convert_sum();
               end
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_digits.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction digit %0d last %0b empty %0b",
                                         rsp_mon.digit_value_res, rsp_mon.last,
                                         rsp_mon.empty_res));
            end else begin
               want = expected_digits.pop_front();
               if (rsp_mon.digit_value_res !== want.digit)
                  report_mismatch($sformatf("digit_value_res %0d, expected %0d",
                                            rsp_mon.digit_value_res, want.digit));
               if (rsp_mon.last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_mon.last, want.last));
               if (rsp_mon.empty_res !== want.empty)
                  report_mismatch($sformatf("empty_res %0b, expected %0b",
                                            rsp_mon.empty_res, want.empty));
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_digits.size();
   end

endmodule

### test/tb_balanced_quinary_sum_converter_top.sv
// Testbench top: clock, reset, request stimulus, response stalls and the verdict
`timescale 1ns / 1ps
module tb_balanced_quinary_sum_converter_top;
   import bqsc_pkg::*;

   localparam int VALUE_WIDTH  = 64;
   localparam int MAX_DIGITS   = 28;
   localparam int RANDOM_ITEMS = 180;
   localparam int TAIL_CYCLES  = 150;
   localparam int LIMIT_CYCLES = 600000;

   localparam action_type ACT_UNUSED = 2'd3;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   int   error_count;
   int   pending_count;
   int   burst_left;
   int   items_sent;
   int   cycle_count = 0;

   bqsc_req_if req_if();
   bqsc_rsp_if rsp_if();

   balanced_quinary_sum_converter_top #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   bqsc_sum_checker #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stalls: open, random, periodic or long stalls, in a mode redrawn at random
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_timer = 0;
   int          rx_hold = 0;
   logic        rx_low = 1'b0;

   always @(posedge clock) begin
      rx_timer++;
      if (rx_timer % 300 == 0)
         rx_mode = rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN: begin
            rsp_if.ready <= 1'b1;
         end
         RX_RANDOM: begin
            rsp_if.ready <= ($urandom_range(0, 3) != 0);
         end
         RX_PERIODIC: begin
            rsp_if.ready <= ((rx_timer % 7) < 4);
         end
         default: begin
            if (rx_hold == 0) begin
               rx_hold = $urandom_range(1, 25);
               rx_low  = ~rx_low;
            end
            rx_hold--;
            rsp_if.ready <= !rx_low;
         end
      endcase
   end

   // one request transaction, in bursts with random gaps
   task automatic push_item(input action_type act, input logic signed [2:0] dig);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.digit_value <= dig;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      burst_left--;
      if (act != ACT_UNUSED)
         items_sent++;
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // leading digit mostly positive so that most sums come out positive
   task automatic push_number(input int len);
      int i;
      if (len > 0) begin
         if ($urandom_range(0, 4) != 0)
            push_item(ACT_DIGIT, 3'($urandom_range(1, 2)));
         else
            push_item(ACT_DIGIT, 3'($urandom_range(0, 4) - 2));
      end
      for (i = 1; i < len; i++)
         push_item(ACT_DIGIT, 3'($urandom_range(0, 4) - 2));
   endtask

   initial begin
      int kind;
      int nums;
      int len;
      int j;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.action      = ACT_DIGIT;
      req_if.digit_value = '0;
      burst_left         = 0;
      items_sent         = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero sum
      push_item(ACT_FINISH, 3'sd0);
      // every in-range digit value
      push_item(ACT_DIGIT, 3'sd2);
      push_item(ACT_DIGIT, -3'sd2);
      push_item(ACT_DIGIT, 3'sd1);
      push_item(ACT_DIGIT, -3'sd1);
      push_item(ACT_DIGIT, 3'sd0);
      push_item(ACT_END, 3'sd0);
      push_item(ACT_FINISH, 3'sd0);
      // out-of-range digits, unused action, empty number, pending number at finish
      push_item(ACT_DIGIT, 3'sd3);
      push_item(ACT_DIGIT, 3'b100);
      push_item(ACT_UNUSED, 3'b111);
      push_item(ACT_END, 3'b011);
      push_item(ACT_END, 3'sd0);
      push_item(ACT_DIGIT, 3'sd1);
      push_item(ACT_DIGIT, -3'sd3);
      push_item(ACT_FINISH, 3'sd0);
      // negative sum
      push_item(ACT_DIGIT, -3'sd1);
      push_item(ACT_FINISH, 3'sd0);
      // single-digit result
      push_item(ACT_DIGIT, 3'sd2);
      push_item(ACT_FINISH, 3'sd0);
      wait_drained();

      while (items_sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            nums = $urandom_range(1, 4);
            for (j = 0; j < nums; j++)
               push_item(action_type'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
         end else begin
            nums = $urandom_range(1, 3);
            for (j = 0; j < nums; j++) begin
               len = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 30)
                                                 : $urandom_range(0, 8);
               push_number(len);
               if (j < nums - 1 || $urandom_range(0, 9) < 7)
                  push_item(ACT_END, 3'($urandom_range(0, 7)));
            end
            push_item(ACT_FINISH, 3'($urandom_range(0, 7)));
         end
         if ($urandom_range(0, 15) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
